### sv/ard_pkg.sv
// Shared widths, codes and defaults for the accelerating rise detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package ard_pkg;

  localparam int SAMPLE_W = 32;                     // sample and latch width
  localparam int TIME_W = 48;                       // tick counter width
  localparam int LEN_W = 5;                         // window length register width
  localparam int CNT_W = 4;                         // half-window increment count
  localparam int DIVISOR_W = SAMPLE_W + LEN_W;      // (n-1) * spacing
  localparam int PROD_W = SAMPLE_W + CNT_W;         // half-sum cross products
  localparam int CFG_IDX_W = 2;
  localparam int WINDOW_MAX_DEF = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

  // Operation codes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_REARM = 1'b1;

  // Divider handshake towards the control logic
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### sv/ard_sample_mem.sv
// Sample window store: one write port, one read port, registered read data.
// Depends on ard_pkg for the sample width.
`default_nettype none

module ard_sample_mem
  import ard_pkg::*;
#(
  parameter int Depth = WINDOW_MAX_DEF,
  parameter int AddrW = $clog2(WINDOW_MAX_DEF)
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  wire logic [SAMPLE_W-1:0] wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  output logic      [SAMPLE_W-1:0] rd_data_o
);

  logic [SAMPLE_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### sv/ard_rate_div.sv
// Restoring divider for the rise rate, one quotient bit per cycle.
// Depends on ard_pkg for widths and the status struct.
`default_nettype none

module ard_rate_div
  import ard_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [SAMPLE_W-1:0]  dividend_i,
  input  wire logic [DIVISOR_W-1:0] divisor_i,
  output div_status_t               status_o,
  output logic      [SAMPLE_W-1:0]  quotient_o
);

  localparam int StepW = $clog2(SAMPLE_W + 1);

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [SAMPLE_W-1:0]  quot_q, quot_d;
  logic [DIVISOR_W-1:0] divisor_q, divisor_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem_q, quot_q[SAMPLE_W-1]};
  assign fits = shifted >= {1'b0, divisor_q};

  always_comb begin
    rem_d = rem_q;
    quot_d = quot_q;
    divisor_d = divisor_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quot_d = dividend_i;
      divisor_d = divisor_i;
      step_d = StepW'(SAMPLE_W);
    end else if (step_q != '0) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_d = fits ? DIVISOR_W'(shifted - {1'b0, divisor_q}) : shifted[DIVISOR_W-1:0];
      quot_d = {quot_q[SAMPLE_W-2:0], fits};
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
      rem_q <= '0;
      quot_q <= '0;
      divisor_q <= '0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
      rem_q <= rem_d;
      quot_q <= quot_d;
      divisor_q <= divisor_d;
    end
  end

  assign status_o.busy = (step_q != '0);
  assign status_o.done = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

### sv/accelerating_rise_detector_unit.sv
// Accelerating rise detector: top level with control sequencer and latches.
// Depends on ard_pkg, ard_sample_mem and ard_rate_div.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries op_i, now_ticks_i and
//   sample_value_i. A transaction is taken when valid is high and stall low.
//   Every input transaction yields exactly one output transaction on
//   out_valid_o / out_stall_i with alarm_o, sample_taken_o, halt_sample_o
//   and rise_rate_o.
//   Configuration writes use cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i (0 threshold, 1 sample spacing, 2 window length); write only
//   while no transaction is in flight.
// Sequencing
//   One transaction at a time. A judged window of n samples walks n-1 stored
//   entries through the single memory read port, then passes the judge and
//   decide states before the output is loaded; an alarm also runs the divider.
// Reset and back-pressure
//   Reset clears window fill, due time and latches; the sample store is not
//   cleared, as entries are only read after being written since a rearm.
//   The output register holds a finished result while out_stall_i is high;
//   the next input transaction is still taken and processed, then waits.
`default_nettype none

module accelerating_rise_detector_unit
  import ard_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 op_i,
  input  wire logic [TIME_W-1:0]    now_ticks_i,
  input  wire logic [SAMPLE_W-1:0]  sample_value_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      alarm_o,
  output logic                      sample_taken_o,
  output logic      [SAMPLE_W-1:0]  halt_sample_o,
  output logic      [SAMPLE_W-1:0]  rise_rate_o,
  // configuration channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SAMPLE_W-1:0]  cfg_data_i
);

  localparam int PtrW = $clog2(WINDOW_MAX);
  localparam int IdxW = PtrW + LEN_W + 1;   // room for head + depth - offset

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LAST,
    ST_JUDGE,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [SAMPLE_W-1:0] thr_q;
  logic [SAMPLE_W-1:0] spacing_q;
  logic [LEN_W-1:0]    len_q;

  // persistent detector state
  logic [PtrW-1:0]     head_q;
  logic [LEN_W-1:0]    fill_q;
  logic [TIME_W-1:0]   due_q;
  logic                alarm_latched_q;
  logic [SAMPLE_W-1:0] lat_sample_q;
  logic [SAMPLE_W-1:0] lat_rate_q;

  // per-transaction working registers
  logic [SAMPLE_W-1:0]  sample_q;
  logic [LEN_W-1:0]     k_q;
  logic                 pend_q;
  logic [LEN_W-1:0]     pend_k_q;
  logic                 fail_q;
  logic [SAMPLE_W-1:0]  oldest_q;
  logic [SAMPLE_W-1:0]  mid_q;
  logic                 cond_q;
  logic [PROD_W-1:0]    prod_late_q;
  logic [PROD_W-1:0]    prod_early_q;
  logic [DIVISOR_W-1:0] divisor_q;
  logic                 res_alarm_q;
  logic                 res_taken_q;

  // output register
  logic                 out_valid_q;
  logic                 out_alarm_q;
  logic                 out_taken_q;
  logic [SAMPLE_W-1:0]  out_halt_q;
  logic [SAMPLE_W-1:0]  out_rate_q;

  // decode of the incoming transaction
  logic                 disabled;
  logic                 early;
  logic [PtrW-1:0]      head_next;
  logic [LEN_W-1:0]     fill_next;
  logic [TIME_W:0]      due_sum;
  logic [TIME_W-1:0]    due_next;
  logic                 keep;

  // window walk and judgement
  logic [LEN_W-1:0]     incs;
  logic [CNT_W-1:0]     cnt_early;
  logic [CNT_W-1:0]     cnt_late;
  logic [LEN_W-1:0]     mid_k;
  logic [IdxW-1:0]      idx_sum;
  logic [PtrW-1:0]      rd_addr;
  logic [SAMPLE_W-1:0]  rd_data;
  logic                 fire;
  logic                 out_load;

  div_status_t          div_status;
  logic [SAMPLE_W-1:0]  div_quot;
  logic                 div_start;

  assign disabled = (thr_q == '0) || (spacing_q == '0) || (len_q < LEN_MIN) ||
                    (32'(len_q) > 32'(WINDOW_MAX));
  assign early = now_ticks_i < due_q;
  assign head_next = (32'(head_q) == WINDOW_MAX - 1) ? '0 : head_q + PtrW'(1);
  assign fill_next = (fill_q < len_q) ? fill_q + LEN_W'(1) : fill_q;
  assign due_sum = {1'b0, now_ticks_i} + (TIME_W + 1)'(spacing_q);
  // saturate rather than wrap
  assign due_next = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
  assign keep = (state_q == ST_IDLE) && in_valid_i && (op_i == OP_OBSERVE) &&
                !disabled && !early;

  // increments split: early half takes the floor, late half the rest
  assign incs = len_q - LEN_W'(1);
  assign cnt_early = CNT_W'(incs >> 1);
  assign cnt_late = CNT_W'(incs - (incs >> 1));
  assign mid_k = incs - (incs >> 1);

  // entry k back from the newest lives at (head - k) mod depth
  always_comb begin
    idx_sum = IdxW'(head_q) + IdxW'(WINDOW_MAX) - IdxW'(k_q);
    if (idx_sum >= IdxW'(WINDOW_MAX)) begin
      idx_sum = idx_sum - IdxW'(WINDOW_MAX);
    end
  end
  assign rd_addr = idx_sum[PtrW-1:0];

  assign fire = cond_q && (prod_late_q >= prod_early_q);
  assign div_start = (state_q == ST_DECIDE) && fire;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  ard_sample_mem #(
    .Depth (WINDOW_MAX),
    .AddrW (PtrW)
  ) u_sample_mem (
    .clk_i     (clk_i),
    .wr_en_i   (keep),
    .wr_addr_i (head_next),
    .wr_data_i (sample_value_i),
    .rd_en_i   (state_q == ST_WALK),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ard_rate_div u_rate_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sample_q - oldest_q),
    .divisor_i  (divisor_q),
    .status_o   (div_status),
    .quotient_o (div_quot)
  );

  // configuration registers; write only while the block is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      spacing_q <= '0;
      len_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_SPACING:   spacing_q <= cfg_data_i;
        CFG_LENGTH:    len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, detector state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q <= '0;
      fill_q <= '0;
      due_q <= '0;
      alarm_latched_q <= 1'b0;
      lat_sample_q <= '0;
      lat_rate_q <= '0;
      sample_q <= '0;
      k_q <= '0;
      pend_q <= 1'b0;
      pend_k_q <= '0;
      fail_q <= 1'b0;
      oldest_q <= '0;
      mid_q <= '0;
      cond_q <= 1'b0;
      prod_late_q <= '0;
      prod_early_q <= '0;
      divisor_q <= '0;
      res_alarm_q <= 1'b0;
      res_taken_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_alarm_q <= 1'b0;
      out_taken_q <= 1'b0;
      out_halt_q <= '0;
      out_rate_q <= '0;
    end else begin
      // drop the output transaction once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      // fold in read data from the previous walk cycle
      if (pend_q) begin
        if (rd_data <= thr_q) begin
          fail_q <= 1'b1;
        end
        if (pend_k_q == incs) begin
          oldest_q <= rd_data;
        end
        if (pend_k_q == mid_k) begin
          mid_q <= rd_data;
        end
      end
      pend_q <= (state_q == ST_WALK);

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= sample_value_i;
            res_alarm_q <= 1'b0;
            res_taken_q <= 1'b0;
            state_q <= ST_DONE;
            if (op_i == OP_REARM) begin
              alarm_latched_q <= 1'b0;
              lat_sample_q <= '0;
              lat_rate_q <= '0;
              fill_q <= '0;
              due_q <= now_ticks_i;
            end else if (disabled) begin
              // hold everything
            end else if (early) begin
              res_alarm_q <= alarm_latched_q;
            end else begin
              head_q <= head_next;
              fill_q <= fill_next;
              due_q <= due_next;
              res_taken_q <= 1'b1;
              if (fill_next >= len_q) begin
                k_q <= incs;
                fail_q <= (sample_value_i <= thr_q);
                state_q <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          pend_k_q <= k_q;
          if (k_q == LEN_W'(1)) begin
            state_q <= ST_LAST;
          end else begin
            k_q <= k_q - LEN_W'(1);
          end
        end
        ST_LAST: begin
          state_q <= ST_JUDGE;
        end
        ST_JUDGE: begin
          // telescoped half sums: late = newest - mid, early = mid - oldest
          cond_q <= !fail_q && (sample_q > oldest_q) && (mid_q > oldest_q) &&
                    (sample_q > mid_q);
          prod_late_q <= PROD_W'(sample_q - mid_q) * PROD_W'(cnt_early);
          prod_early_q <= PROD_W'(mid_q - oldest_q) * PROD_W'(cnt_late);
          divisor_q <= DIVISOR_W'(incs) * DIVISOR_W'(spacing_q);
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state_q <= fire ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_status.done) begin
            alarm_latched_q <= 1'b1;
            lat_sample_q <= sample_q;
            lat_rate_q <= div_quot;
            res_alarm_q <= 1'b1;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_alarm_q <= res_alarm_q;
            out_taken_q <= res_taken_q;
            out_halt_q <= lat_sample_q;
            out_rate_q <= lat_rate_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign alarm_o = out_alarm_q;
  assign sample_taken_o = out_taken_q;
  assign halt_sample_o = out_halt_q;
  assign rise_rate_o = out_rate_q;

endmodule

`default_nettype wire

### sv/ard_checker.sv
// Port-level checks for the accelerating rise detector, bound to the top.
// Depends on ard_pkg for widths.
`default_nettype none

module ard_checker
  import ard_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                alarm_o,
  input wire logic                sample_taken_o,
  input wire logic [SAMPLE_W-1:0] halt_sample_o,
  input wire logic [SAMPLE_W-1:0] rise_rate_o
);

  // one transaction in flight: stall rises straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous transaction still in flight");

  // any reported alarm carries a latched sample above a non-zero threshold
  a_alarm_has_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_o |-> halt_sample_o != '0)
    else $error("alarm reported with empty halt sample");

  // an empty latch never reports a rate or an alarm
  a_rate_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (halt_sample_o == '0) |-> (rise_rate_o == '0) && !alarm_o)
    else $error("rate or alarm without latched sample");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alarm_o) &&
      $stable(sample_taken_o) && $stable(halt_sample_o) && $stable(rise_rate_o))
    else $error("output transaction changed while stalled");

endmodule

bind accelerating_rise_detector_unit ard_checker u_ard_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .alarm_o        (alarm_o),
  .sample_taken_o (sample_taken_o),
  .halt_sample_o  (halt_sample_o),
  .rise_rate_o    (rise_rate_o)
);

`default_nettype wire

### tb/tb_accelerating_rise_detector_unit.sv
// Self-checking testbench for accelerating_rise_detector_unit: a directed table
// followed by random sampling runs, checked against an in-bench predictor or typed-in results.
// Depends on ard_pkg and the accelerating_rise_detector_unit RTL.
module tb_accelerating_rise_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ard_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int ITEM_TARGET = 1100;
  localparam int MAX_REPORTS = 50;                  // cap on printed mismatches
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One result transaction as the output channel presents it
  typedef struct packed {
    logic                alarm;
    logic                taken;
    logic [SAMPLE_W-1:0] halt;
    logic [SAMPLE_W-1:0] rate;
  } report_t;

  localparam report_t NO_REPORT = '0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // Directed row: either a register write or an input transaction; 'fixed'
  // marks rows whose result is typed in rather than predicted
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [SAMPLE_W-1:0]  data;
    logic                 op;
    logic [TIME_W-1:0]    now;
    logic [SAMPLE_W-1:0]  smp;
    logic                 fixed;
    report_t              want;
  } script_row_t;

  localparam int N_ROWS = 39;
  localparam script_row_t SCRIPT [N_ROWS] = '{
    // after reset: threshold and spacing are zero, so the block is disabled
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd0, 32'd5, 1'b1, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_REARM, 48'd0, 32'd0, 1'b1, NO_REPORT},
    '{ROW_CFG, CFG_THRESHOLD, 32'd100, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_SPACING, 32'd10, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_LENGTH, 32'd3, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    // fill a three-sample window, with one skipped sample in between
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd0, 32'd200, 1'b1,
      '{1'b0, 1'b1, 32'd0, 32'd0}},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd5, 32'd300, 1'b1, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd10, 32'd210, 1'b1,
      '{1'b0, 1'b1, 32'd0, 32'd0}},
    // increments 10 then 20: alarm, rate 30 / (2 * 10)
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd20, 32'd230, 1'b1,
      '{1'b1, 1'b1, 32'd230, 32'd1}},
    // skipped sample reports the held alarm
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd25, 32'd0, 1'b1,
      '{1'b1, 1'b0, 32'd230, 32'd1}},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd30, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd40, 32'd150, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd50, 32'd100, 1'b0, NO_REPORT},
    // due time saturation at the top of the tick range
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_REARM, 48'hFFFF_FFFF_FFFB, 32'd0, 1'b1, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFB, 32'd500, 1'b0,
      NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFE, 32'd600, 1'b0,
      NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd700, 1'b0,
      NO_REPORT},
    // largest register values: nothing can exceed the threshold
    '{ROW_CFG, CFG_THRESHOLD, 32'hFFFF_FFFF, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_SPACING, 32'hFFFF_FFFF, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_LENGTH, 32'd16, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_REARM, 48'd0, 32'd0, 1'b1, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd0, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
    // window length above the store depth disables the block
    '{ROW_CFG, CFG_LENGTH, 32'd31, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b1,
      NO_REPORT},
    // too short a window, zero spacing and zero threshold each disable it
    '{ROW_CFG, CFG_LENGTH, 32'd2, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd2, 1'b0,
      NO_REPORT},
    '{ROW_CFG, CFG_LENGTH, 32'd4, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_THRESHOLD, 32'd1, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_SPACING, 32'd0, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd3, 1'b0,
      NO_REPORT},
    '{ROW_CFG, CFG_SPACING, 32'd1, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd4, 1'b0,
      NO_REPORT},
    // even window: unequal half-window increment counts
    '{ROW_CFG, CFG_THRESHOLD, 32'd1, OP_OBSERVE, 48'd0, 32'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_REARM, 48'd100, 32'd0, 1'b1, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd100, 32'd10, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd101, 32'd11, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd102, 32'd13, 1'b0, NO_REPORT},
    '{ROW_ITEM, CFG_THRESHOLD, 32'd0, OP_OBSERVE, 48'd103, 32'd17, 1'b0, NO_REPORT}
  };

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_PERIODIC}
    stall_mode_e;

  // DUT ports; every input starts at a known value
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 op_i = OP_OBSERVE;
  logic [TIME_W-1:0]    now_ticks_i = '0;
  logic [SAMPLE_W-1:0]  sample_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 alarm_o;
  logic                 sample_taken_o;
  logic [SAMPLE_W-1:0]  halt_sample_o;
  logic [SAMPLE_W-1:0]  rise_rate_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_THRESHOLD;
  logic [SAMPLE_W-1:0]  cfg_data_i = '0;

  // Predictor copy of the registers and detector state, at reset values
  logic [SAMPLE_W-1:0]  level_thr = '0;
  logic [SAMPLE_W-1:0]  spacing = '0;
  logic [LEN_W-1:0]     win_len = LEN_RESET;
  logic [SAMPLE_W-1:0]  kept [WINDOW_MAX_DEF] = '{default: '0};
  int unsigned          fill = 0;
  logic [TIME_W-1:0]    due_at = '0;
  logic                 alarm_held = 1'b0;
  logic [SAMPLE_W-1:0]  held_sample = '0;
  logic [SAMPLE_W-1:0]  held_rate = '0;

  report_t              expected_reports [$];
  int unsigned          mismatches = 0;
  int unsigned          items_sent = 0;
  int                   burst_left = 1;
  int                   gap_left = 0;
  logic [TIME_W-1:0]    tick = '0;

  stall_mode_e          stall_mode = STALL_NONE;
  int                   mode_left = 0;
  int unsigned          stall_phase = 0;

  accelerating_rise_detector_unit i_dut (.*);

  always #CLK_HALF clk_i = ~clk_i;

  // Judge the newest n kept samples: all above threshold, newest above oldest,
  // both half sums positive and the later half mean not below the earlier one
  function automatic bit window_rises(int unsigned n);
    int unsigned half1, half2, older, k;
    longint sum1, sum2, d;
    half1 = (n - 1) / 2;
    half2 = (n - 1) - half1;
    sum1 = 0;
    sum2 = 0;
    for (k = 0; k < n; k++) begin
      if (kept[k] <= level_thr) return 1'b0;
    end
    // walk the increments from the oldest sample towards the newest
    for (k = 0; k < n - 1; k++) begin
      older = n - 1 - k;
      d = longint'(kept[older-1]) - longint'(kept[older]);
      if (k < half1) sum1 += d;
      else sum2 += d;
    end
    if (kept[0] <= kept[n-1]) return 1'b0;
    if (sum1 <= 0 || sum2 <= 0) return 1'b0;
    // compare the means without dividing
    return sum2 * longint'(half1) >= sum1 * longint'(half2);
  endfunction

  // Advance the predicted detector by one input transaction
  function automatic report_t step_detector(logic op, logic [TIME_W-1:0] now,
                                            logic [SAMPLE_W-1:0] smp);
    report_t         r;
    int unsigned     n, k;
    bit              enabled;
    logic [TIME_W:0] due;
    logic [63:0]     rise, divisor;
    n = win_len;
    r = NO_REPORT;
    enabled = level_thr != 0 && spacing != 0 && n >= LEN_MIN && n <= WINDOW_MAX_DEF;
    if (op == OP_REARM) begin
      alarm_held = 1'b0;
      held_sample = '0;
      held_rate = '0;
      fill = 0;
      due_at = now;
    end else if (enabled && now < due_at) begin
      r.alarm = alarm_held;
    end else if (enabled) begin
      for (k = WINDOW_MAX_DEF - 1; k > 0; k--) kept[k] = kept[k-1];
      kept[0] = smp;
      if (fill < n) fill++;
      due = now + spacing;
      due_at = due[TIME_W] ? TIME_MAX : due[TIME_W-1:0];
      r.taken = 1'b1;
      if (fill >= n && window_rises(n)) begin
        rise = 64'(kept[0]) - 64'(kept[n-1]);
        divisor = 64'(n - 1) * 64'(spacing);
        alarm_held = 1'b1;
        held_sample = smp;
        held_rate = SAMPLE_W'(rise / divisor);
        r.alarm = 1'b1;
      end
    end
    r.halt = held_sample;
    r.rate = held_rate;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] later(logic [TIME_W-1:0] t, logic [TIME_W-1:0] step);
    logic [TIME_W:0] sum;
    sum = t + step;
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // Drop both request lines and hold until every expected result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register; only ever done with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
    if (in_valid_i || expected_reports.size() != 0) settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_THRESHOLD: level_thr = data;
      CFG_SPACING:   spacing = data;
      CFG_LENGTH:    win_len = data[LEN_W-1:0];
      default:       ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one input transaction; valid is left high afterwards so that a
  // following transaction can go out back to back
  task automatic send_item(logic op, logic [TIME_W-1:0] now, logic [SAMPLE_W-1:0] smp,
                           bit fixed = 1'b0, report_t want = NO_REPORT);
    report_t r;
    cfg_valid_i <= 1'b0;
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_left) @(negedge clk_i);
      gap_left = 0;
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    now_ticks_i <= now;
    sample_value_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    r = step_detector(op, now, smp);
    expected_reports.insert(expected_reports.size(), fixed ? want : r);
    items_sent++;
    @(negedge clk_i);
    // end of burst: choose the next burst length and the gap before it
    if (--burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
    end
  endtask

  // One random phase: new register values, a rearm, then a few runs that are
  // mostly accelerating sequences with random content and some noise
  task automatic run_phase();
    logic [SAMPLE_W-1:0] thr, spc, smp;
    logic [LEN_W-1:0]    len;
    logic [63:0]         base, a, b, v, k64;
    logic [TIME_W-1:0]   adv;
    logic                op;
    int unsigned         runs, steps, n_eff, k, j;
    case ($urandom_range(0, 15))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = $urandom;
      3:       thr = $urandom_range(32'hF000_0000, 32'hFFFF_F000);
      default: thr = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 15))
      0:       spc = '0;
      1:       spc = '1;
      2:       spc = $urandom;
      3:       spc = $urandom_range(1000, 100000);
      default: spc = $urandom_range(1, 50);
    endcase
    case ($urandom_range(0, 15))
      0:       len = LEN_W'($urandom_range(0, 2));
      1:       len = LEN_W'($urandom_range(17, 31));
      2, 3:    len = LEN_W'(WINDOW_MAX_DEF);
      default: len = LEN_W'($urandom_range(3, 16));
    endcase
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_SPACING, spc);
    write_register(CFG_LENGTH, SAMPLE_W'(len));

    // occasionally jump the clock, near the top of the range or anywhere
    case ($urandom_range(0, 19))
      0:       tick = TIME_MAX - TIME_W'($urandom_range(0, 2000));
      1:       tick = TIME_W'({$urandom, $urandom});
      default: ;
    endcase
    send_item(OP_REARM, tick, $urandom);

    runs = $urandom_range(1, 4);
    for (j = 0; j < runs; j++) begin
      if ($urandom_range(0, 3) != 0) begin
        n_eff = (len >= LEN_MIN && len <= WINDOW_MAX_DEF) ? len : $urandom_range(3, 8);
        steps = n_eff + $urandom_range(0, 4);
        base = 64'(thr) + 1 + $urandom_range(0, 300);
        a = $urandom_range(0, 40);
        b = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1 << 22) : $urandom_range(1, 20);
        for (k = 0; k < steps; k++) begin
          k64 = k;
          v = base + a * k64 + b * k64 * k64;
          smp = (v > 64'hFFFF_FFFF) ? '1 : v[SAMPLE_W-1:0];
          if ($urandom_range(0, 9) == 0) smp = $urandom;          // break the sequence
          case ($urandom_range(0, 19))
            0, 1:    adv = $urandom_range(0, spc);                 // likely skipped
            2:       adv = $urandom;
            default: adv = TIME_W'(spc) + $urandom_range(0, 2);
          endcase
          tick = later(tick, adv);
          op = ($urandom_range(0, 39) == 0) ? OP_REARM : OP_OBSERVE;
          send_item(op, tick, smp);
          if ($urandom_range(0, 99) == 0) settle();
        end
      end else begin
        steps = $urandom_range(4, 16);
        for (k = 0; k < steps; k++) begin
          adv = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                            : TIME_W'($urandom_range(0, spc)) + 3;
          tick = later(tick, adv);
          op = ($urandom_range(0, 7) == 0) ? OP_REARM : OP_OBSERVE;
          send_item(op, tick, $urandom);
        end
      end
    end
  endtask

  // Output side: stall on a pattern of its own, changing mode now and then
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(30, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_SPARSE: out_stall_i <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 7) != 0);
      default:      out_stall_i <= (stall_phase % 11) < 4;
    endcase
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{alarm_o, sample_taken_o, halt_sample_o, rise_rate_o};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected, actual %h", $time, got);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            if (got.alarm !== want.alarm)
              $display("%0t: alarm expected %b actual %b", $time, want.alarm, got.alarm);
            if (got.taken !== want.taken)
              $display("%0t: sample_taken expected %b actual %b", $time, want.taken,
                       got.taken);
            if (got.halt !== want.halt)
              $display("%0t: halt_sample expected %h actual %h", $time, want.halt, got.halt);
            if (got.rate !== want.rate)
              $display("%0t: rise_rate expected %h actual %h", $time, want.rate, got.rate);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    int i;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < N_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) write_register(SCRIPT[i].idx, SCRIPT[i].data);
      else send_item(SCRIPT[i].op, SCRIPT[i].now, SCRIPT[i].smp, SCRIPT[i].fixed,
                     SCRIPT[i].want);
    end
    while (items_sent < ITEM_TARGET) run_phase();
    settle();
    // allow for a late result beyond the last expected one
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
